[rtl/tick_task_scheduler_table_assert.svh]
// assertion helpers for the scheduler top module
`ifndef TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tts_pkg.sv]
package tts_pkg;

  localparam int MAX_TASKS    = 16;
  localparam int TICK_MS      = 10;
  localparam int RESULT_LIMIT = 16;

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int RES_W  = $clog2(RESULT_LIMIT + 1);
  localparam int TIU_W  = 5;
  localparam int TAG_W  = 8;
  localparam int MS_W   = 20;
  localparam int TCK_W  = 16;
  localparam int RUNS_W = 8;

  // ms to ticks by reciprocal multiply
  localparam int RECIP_SH = MS_W + 1;
  localparam longint RECIP = (64'd1 << RECIP_SH) / TICK_MS;
  localparam int PROD_W   = MS_W + RECIP_SH + 1;
  localparam int TMUL_W   = $clog2(TICK_MS + 1);
  localparam int BACK_W   = MS_W + TMUL_W;

  // action codes
  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_TICK     = 2'd1;
  localparam logic [1:0] ACT_DISPATCH = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  // result status codes
  localparam logic [2:0] STS_ADDED = 3'd0;
  localparam logic [2:0] STS_FULL  = 3'd1;
  localparam logic [2:0] STS_TICK  = 3'd2;
  localparam logic [2:0] STS_RUN   = 3'd3;
  localparam logic [2:0] STS_IDLE  = 3'd4;

  // cell update codes
  localparam logic [1:0] CELL_KEEP = 2'd0;
  localparam logic [1:0] CELL_TICK = 2'd1;
  localparam logic [1:0] CELL_DEC  = 2'd2;
  localparam logic [1:0] CELL_LOAD = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [TAG_W-1:0] task_tag;
    logic [MS_W-1:0]  delay_ms;
    logic [MS_W-1:0]  period_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TAG_W-1:0] run_tag;
    logic [TIU_W-1:0] tasks_in_use;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TCK_W-1:0]  delay;
    logic [TCK_W-1:0]  period;
    logic [RUNS_W-1:0] runs;
  } entry_t;

  typedef struct packed {
    logic       shift;
    logic [1:0] op;
    entry_t     rep;
  } cell_cmd_t;

endpackage

[rtl/tts_cell.sv]
module tts_cell (
  input  logic               clk,
  input  tts_pkg::cell_cmd_t cmd,
  input  tts_pkg::entry_t    nbr,
  output tts_pkg::entry_t    ent
);

  tts_pkg::entry_t ent_r;
  tts_pkg::entry_t ent_nxt;

  // take the neighbor's entry, updated on the way in
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.shift) begin
      ent_nxt = nbr;
      unique case (cmd.op)
        tts_pkg::CELL_KEEP: ent_nxt = nbr;
        tts_pkg::CELL_TICK: begin
          if (nbr.delay != '0) begin
            ent_nxt.delay = nbr.delay - 16'd1;
          end else begin
            ent_nxt.delay = nbr.period;
            if (nbr.runs != '1) begin
              ent_nxt.runs = nbr.runs + 8'd1;
            end
          end
        end
        tts_pkg::CELL_DEC: ent_nxt.runs = nbr.runs - 8'd1;
        tts_pkg::CELL_LOAD: ent_nxt = cmd.rep;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

[rtl/tts_conv.sv]
module tts_conv (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tts_pkg::MS_W-1:0]  ms,
  output logic [tts_pkg::TCK_W-1:0] ticks
);

  localparam int MSW  = tts_pkg::MS_W;
  localparam int TKW  = tts_pkg::TCK_W;
  localparam int PW   = tts_pkg::PROD_W;
  localparam int BW   = tts_pkg::BACK_W;
  localparam int SH   = tts_pkg::RECIP_SH;

  logic [PW-1:0]  prod;
  logic [MSW-1:0] q0_r;
  logic [MSW-1:0] q0_nxt;
  logic [BW-1:0]  back_full;
  logic [MSW-1:0] rem;
  logic [MSW-1:0] q;

  // estimate is exact or one low
  assign prod   = PW'(ms) * PW'(tts_pkg::RECIP);
  assign q0_nxt = prod[SH +: MSW];

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r <= q0_nxt;
    end
  end

  // remainder check fixes the estimate
  assign back_full = BW'(q0_r) * BW'(tts_pkg::TICK_MS);
  assign rem       = ms - back_full[MSW-1:0];
  assign q         = (rem >= MSW'(tts_pkg::TICK_MS)) ? q0_r + MSW'(1) : q0_r;
  assign ticks     = (|q[MSW-1:TKW]) ? '1 : q[TKW-1:0];

endmodule

[rtl/tick_task_scheduler_table.sv]
// task table walk: each add, tick or dispatch item takes one full turn of the cell ring
//   between the prepare and done states; no new item is taken until the block is idle again
// final result registered in the done state, after the prepare state and the walk;
//   a stall on a run result holds the walk, and a stall holds the done state
// action 3 is taken in the idle state and gives no result
// reset clears the task count and the handshake state; table cells are not cleared
module tick_task_scheduler_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_data
);

  localparam int N  = tts_pkg::MAX_TASKS;
  localparam int IW = tts_pkg::IDX_W;
  localparam int CW = tts_pkg::CNT_W;
  localparam int RW = tts_pkg::RES_W;
  localparam int TW = tts_pkg::TIU_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  tts_pkg::in_item_t  op_r;
  logic [IW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [RW-1:0]      nres_r, nres_nxt;
  logic               add_ok_r, add_ok_nxt;
  logic               pend_v_r, pend_v_nxt;
  tts_pkg::out_item_t pend_r, pend_nxt;
  logic               out_v_r, out_v_nxt;
  tts_pkg::out_item_t out_r, out_nxt;

  tts_pkg::entry_t    ent [N];
  tts_pkg::entry_t    head;
  tts_pkg::entry_t    moved;
  tts_pkg::entry_t    new_ent;
  tts_pkg::cell_cmd_t body_cmd;
  tts_pkg::cell_cmd_t tail_cmd;

  logic [tts_pkg::TCK_W-1:0] delay_tk;
  logic [tts_pkg::TCK_W-1:0] period_tk;

  logic          in_fire;
  logic          out_free;
  logic          examine;
  logic          ready;
  logic          del;
  logic          at_last;
  logic          push_walk;
  logic          advance;
  logic          walk_end;
  logic [CW-1:0] step_ext;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] mv_full;
  logic [IW-1:0] mv_idx;

  // ------------------------------------------------------------------
  // ring of cells: cell k takes cell k+1 each step, the tail takes the
  // head after the update; one full turn brings every entry home
  // ------------------------------------------------------------------
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == N - 1) begin : g_tail
      tts_cell u_cell (
        .clk (clk),
        .cmd (tail_cmd),
        .nbr (ent[0]),
        .ent (ent[k])
      );
    end else begin : g_body
      tts_cell u_cell (
        .clk (clk),
        .cmd (body_cmd),
        .nbr (ent[k+1]),
        .ent (ent[k])
      );
    end
  end

  // ms to ticks for a new task, estimate registered in the prepare cycle
  tts_conv u_conv_delay (
    .clk   (clk),
    .en    (state_r == S_PREP),
    .ms    (op_r.delay_ms),
    .ticks (delay_tk)
  );

  tts_conv u_conv_period (
    .clk   (clk),
    .en    (state_r == S_PREP),
    .ms    (op_r.period_ms),
    .ticks (period_tk)
  );

  assign new_ent.tag    = op_r.task_tag;
  assign new_ent.delay  = delay_tk;
  assign new_ent.period = period_tk;
  assign new_ent.runs   = '0;

  // ------------------------------------------------------------------
  // walk decode: table position step_r sits in cell 0
  // ------------------------------------------------------------------
  assign head      = ent[0];
  assign step_ext  = CW'(step_r);
  assign count_dec = count_r - CW'(1);
  assign examine   = step_ext < count_r;
  assign ready     = (state_r == S_WALK) && (op_r.action == tts_pkg::ACT_DISPATCH) &&
                     examine && (nres_r < RW'(tts_pkg::RESULT_LIMIT)) &&
                     (head.runs != '0);
  assign del       = ready && (head.period == '0);
  assign at_last   = step_ext == count_dec;

  // last valid entry sits count-1-step cells down the ring
  assign mv_full   = count_dec - step_ext;
  assign mv_idx    = mv_full[IW-1:0];
  assign moved     = ent[mv_idx];

  assign out_free  = !out_v_r || !out_stall;
  // a new run result pushes the held one out
  assign push_walk = ready && pend_v_r;
  assign advance   = (state_r == S_WALK) && (!push_walk || out_free);
  assign walk_end  = step_r == IW'(N - 1);
  assign in_fire   = in_valid && !in_stall;

  assign body_cmd.shift = advance;
  assign body_cmd.op    = tts_pkg::CELL_KEEP;
  assign body_cmd.rep   = new_ent;

  // update applied to the head on its way to the tail
  always_comb begin
    tail_cmd.shift = advance;
    tail_cmd.op    = tts_pkg::CELL_KEEP;
    tail_cmd.rep   = new_ent;
    priority if (op_r.action == tts_pkg::ACT_TICK && examine) begin
      tail_cmd.op = tts_pkg::CELL_TICK;
    end else if (op_r.action == tts_pkg::ACT_ADD && add_ok_r && step_ext == count_r) begin
      tail_cmd.op = tts_pkg::CELL_LOAD;
    end else if (ready) begin
      // one-shot task leaves: last entry fills its slot unless it is the last itself
      if (del && !at_last) begin
        tail_cmd.op  = tts_pkg::CELL_LOAD;
        tail_cmd.rep = moved;
      end else begin
        tail_cmd.op = tts_pkg::CELL_DEC;
      end
    end else begin
      tail_cmd.op = tts_pkg::CELL_KEEP;
    end
  end

  // ------------------------------------------------------------------
  // sequencer and result path
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    count_nxt  = count_r;
    nres_nxt   = nres_r;
    add_ok_nxt = add_ok_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;

    // output register drains on a transfer
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.action != tts_pkg::ACT_NONE) begin
          state_nxt  = S_PREP;
          step_nxt   = '0;
          nres_nxt   = '0;
          pend_v_nxt = 1'b0;
        end
      end
      S_PREP: begin
        add_ok_nxt = count_r < CW'(N);
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        if (advance) begin
          if (ready) begin
            if (pend_v_r) begin
              out_nxt   = pend_r;
              out_v_nxt = 1'b1;
            end
            pend_nxt.status       = tts_pkg::STS_RUN;
            pend_nxt.run_tag      = head.tag;
            pend_nxt.tasks_in_use = TW'(del ? count_dec : count_r);
            pend_nxt.last         = 1'b0;
            pend_v_nxt            = 1'b1;
            nres_nxt              = nres_r + RW'(1);
            if (del) begin
              count_nxt = count_dec;
            end
          end
          if (walk_end) begin
            state_nxt = S_DONE;
          end else begin
            step_nxt = step_r + IW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
          unique case (op_r.action)
            tts_pkg::ACT_ADD: begin
              out_nxt.status       = add_ok_r ? tts_pkg::STS_ADDED : tts_pkg::STS_FULL;
              out_nxt.run_tag      = op_r.task_tag;
              out_nxt.tasks_in_use = TW'(add_ok_r ? count_r + CW'(1) : count_r);
              out_nxt.last         = 1'b1;
              if (add_ok_r) begin
                count_nxt = count_r + CW'(1);
              end
            end
            tts_pkg::ACT_TICK: begin
              out_nxt.status       = tts_pkg::STS_TICK;
              out_nxt.run_tag      = '0;
              out_nxt.tasks_in_use = TW'(count_r);
              out_nxt.last         = 1'b1;
            end
            default: begin
              // dispatch: the held run result closes the burst; with none held, an idle result is given
              if (pend_v_r) begin
                out_nxt      = pend_r;
                out_nxt.last = 1'b1;
              end else begin
                out_nxt.status       = tts_pkg::STS_IDLE;
                out_nxt.run_tag      = '0;
                out_nxt.tasks_in_use = TW'(count_r);
                out_nxt.last         = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      count_r  <= '0;
      nres_r   <= '0;
      add_ok_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      count_r  <= count_nxt;
      nres_r   <= nres_nxt;
      add_ok_r <= add_ok_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_data;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `include "tick_task_scheduler_table_assert.svh"

  `TTS_ASSERT_NOW(a_idle_no_pend, state_r == S_IDLE, !pend_v_r, "run result held while idle")
  `TTS_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(N), "task count above table size")
  `TTS_ASSERT_NEXT(a_del_count, advance && del, count_r == $past(count_dec), "delete lost count")
  `TTS_ASSERT_NEXT(a_walk_len, advance && walk_end, state_r == S_DONE, "walk did not finish")
  `TTS_ASSERT_NEXT(a_push_out, advance && push_walk, out_v_r, "run result dropped")

endmodule

[sim/tb_tick_task_scheduler_table.sv]
module tb_tick_task_scheduler_table;
  import tts_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // model of the task table, updated at each accepted input transfer
  int                unsigned tbl_count;
  logic [TAG_W-1:0]  tbl_tag    [MAX_TASKS];
  logic [TCK_W-1:0]  tbl_delay  [MAX_TASKS];
  logic [TCK_W-1:0]  tbl_period [MAX_TASKS];
  logic [RUNS_W-1:0] tbl_runs   [MAX_TASKS];

  // results the block still owes, oldest first
  out_item_t pending_results[$];

  int  mismatch_count;
  // set during the long stretch where neither side idles
  bit  quiet;

  tick_task_scheduler_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 unit clock period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // table model
  // ---------------------------------------------------------------------------

  // ms to ticks, truncating, saturating at the 16-bit tick field
  function automatic logic [TCK_W-1:0] ticks_of(logic [MS_W-1:0] ms);
    int unsigned q;
    q = ms / TICK_MS;
    return (q > 32'hFFFF) ? 16'hFFFF : q[TCK_W-1:0];
  endfunction

  // queue one result; tasks_in_use reflects the table after this result
  function automatic void owe_result(logic [2:0] status, logic [TAG_W-1:0] tag, logic last);
    out_item_t r;
    r.status       = status;
    r.run_tag      = tag;
    r.tasks_in_use = tbl_count[TIU_W-1:0];
    r.last         = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_schedule(in_item_t it);
    int               n;
    int unsigned      tail;
    logic [TAG_W-1:0] run;
    out_item_t        r;
    n = 0;
    case (it.action)
      ACT_ADD: begin
        if (tbl_count < MAX_TASKS) begin
          tbl_tag[tbl_count]    = it.task_tag;
          tbl_delay[tbl_count]  = ticks_of(it.delay_ms);
          tbl_period[tbl_count] = ticks_of(it.period_ms);
          tbl_runs[tbl_count]   = '0;
          tbl_count++;
          owe_result(STS_ADDED, it.task_tag, 1'b1);
        end else begin
          // table full: refused, tag echoed, nothing changes
          owe_result(STS_FULL, it.task_tag, 1'b1);
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] != '0) begin
            tbl_delay[i]--;
          end else begin
            tbl_delay[i] = tbl_period[i];
            if (tbl_runs[i] != 8'hFF) tbl_runs[i]++;
          end
        end
        owe_result(STS_TICK, '0, 1'b1);
      end
      ACT_DISPATCH: begin
        for (int i = 0; i < tbl_count && n < RESULT_LIMIT; i++) begin
          if (tbl_runs[i] != '0) begin
            run = tbl_tag[i];
            tbl_runs[i]--;
            if (tbl_period[i] == '0) begin
              // one-shot done: last entry fills the hole, skipped this pass
              tail = tbl_count - 1;
              if (i != tail) begin
                tbl_tag[i]    = tbl_tag[tail];
                tbl_delay[i]  = tbl_delay[tail];
                tbl_period[i] = tbl_period[tail];
                tbl_runs[i]   = tbl_runs[tail];
              end
              tbl_count--;
            end
            owe_result(STS_RUN, run, 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          owe_result(STS_IDLE, '0, 1'b1);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: ;  // unused action: no result, no change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // compare every result transfer against the oldest owed result
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.run_tag !== want.run_tag)
          report_mismatch("run_tag", out_data.run_tag, want.run_tag);
        if (out_data.tasks_in_use !== want.tasks_in_use)
          report_mismatch("tasks_in_use", out_data.tasks_in_use, want.tasks_in_use);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // receiver stalls at random with a chance of 9 percent, never while quiet
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 9);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one input transfer; valid is held with a fixed payload until taken
  task automatic send_item(logic [1:0] action, logic [TAG_W-1:0] tag,
                           logic [MS_W-1:0] delay_ms, logic [MS_W-1:0] period_ms);
    in_item_t it;
    it.action    = action;
    it.task_tag  = tag;
    it.delay_ms  = delay_ms;
    it.period_ms = period_ms;
    @(negedge clk);
    // sender gap at random with a chance of 9 percent
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_schedule(it);
  endtask

  // dispatch and tick on an empty table, plus the unused action
  task automatic test_empty_table();
    send_item(ACT_DISPATCH, 8'h00, '0, '0);
    send_item(ACT_TICK, 8'hFF, 20'hFFFFF, 20'hFFFFF);
    send_item(ACT_NONE, 8'hC3, 20'hAAAAA, 20'h55555);
  endtask

  // tag and millisecond extremes, saturation of the tick conversion,
  // one-shot removal with the moved entry skipped in the same pass
  task automatic test_add_and_remove();
    send_item(ACT_ADD, 8'h00, 20'd0, 20'd0);             // one-shot, ready on first tick
    send_item(ACT_ADD, 8'hFF, 20'hFFFFF, 20'hFFFFF);     // both saturate to 65535
    send_item(ACT_ADD, 8'h5A, 20'd655350, 20'd9);        // exactly 65535, period rounds to 0
    send_item(ACT_ADD, 8'hA5, 20'd0, 20'd19);            // period of one tick
    send_item(ACT_ADD, 8'h3C, 20'd0, 20'd0);             // one-shot at the tail
    send_item(ACT_TICK, '0, '0, '0);
    // tag 00 leaves, 3C moves into its slot and waits for the next pass
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
  endtask

  // fill every slot and refuse the adds beyond it, then a dispatch with many runs
  task automatic test_table_full();
    for (int i = 0; i < MAX_TASKS; i++)
      send_item(ACT_ADD, TAG_W'(8'h10 + i), MS_W'((i % 2) * 10), MS_W'((i % 5) * 2));
    send_item(ACT_ADD, 8'hE7, 20'd30, 20'd40);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
  endtask

  // the one-tick periodic task piles up a backlog of runs, then drain it
  // also the long stretch without any idling on either side
  task automatic test_run_backlog();
    quiet = 1'b1;
    repeat (60) send_item(ACT_TICK, '0, '0, '0);
    repeat (35) send_item(ACT_DISPATCH, '0, '0, '0);
    quiet = 1'b0;
  endtask

  // mostly short well-formed schedules, some huge times and unused actions
  task automatic test_random_mix(int count);
    int               pick;
    logic [1:0]       action;
    logic [MS_W-1:0]  delay_ms;
    logic [MS_W-1:0]  period_ms;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 33)      action = ACT_ADD;
      else if (pick < 73) action = ACT_TICK;
      else if (pick < 95) action = ACT_DISPATCH;
      else                action = ACT_NONE;
      pick = $urandom_range(99);
      delay_ms = (pick < 5) ? MS_W'($urandom) : MS_W'($urandom_range(50));
      pick = $urandom_range(99);
      if (pick < 5)       period_ms = MS_W'($urandom);
      else if (pick < 25) period_ms = MS_W'($urandom_range(10, 60));
      else                period_ms = MS_W'($urandom_range(9));
      send_item(action, TAG_W'($urandom), delay_ms, period_ms);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    tbl_count      = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_add_and_remove();
    test_table_full();
    test_run_backlog();
    test_random_mix(105);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray result after the last expected one
    repeat (2 * MAX_TASKS + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[tick_task_scheduler_table.f]
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/tts_conv.sv
rtl/tick_task_scheduler_table.sv
sim/tb_tick_task_scheduler_table.sv
